[rtl/rmd_pkg.sv]
package rmd_pkg;

  localparam int unsigned DefBufferDepth = 64;
  localparam logic [15:0] HdrBytes = 16'd4;

  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;

  localparam logic RegStartMarker = 1'b0;
  localparam logic RegIdleLimit = 1'b1;

  localparam logic [7:0] StartMarkerReset = 8'd170;
  localparam logic [7:0] IdleLimitReset = 8'd8;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_ID_LO   = 3'd3,
    PH_ID_HI   = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_HUNT    = 3'd0,
    EV_HEADER  = 3'd1,
    EV_PAYLOAD = 3'd2,
    EV_DONE    = 3'd3,
    EV_TIMEOUT = 3'd4,
    EV_LENERR  = 3'd5
  } event_t;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] idle_limit;
  } cfg_t;

endpackage

[rtl/rmd_regs.sv]
module rmd_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rmd_pkg::AddrWidth-1:0]   paddr,
  input  logic [rmd_pkg::DataWidth-1:0]   pwdata,
  output logic [rmd_pkg::DataWidth-1:0]   prdata,
  output logic                            pready,
  output rmd_pkg::cfg_t                   cfg
);
  import rmd_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker <= StartMarkerReset;
      cfg.idle_limit   <= IdleLimitReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegStartMarker: cfg.start_marker <= pwdata[7:0];
        RegIdleLimit:   cfg.idle_limit   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegStartMarker: prdata = DataWidth'(cfg.start_marker);
      RegIdleLimit:   prdata = DataWidth'(cfg.idle_limit);
      default:        prdata = '0;
    endcase
  end

endmodule

[rtl/response_message_deframer_unit.sv]
// Path: an accepted word is held in the byte register, then moves into the result register.
// Throughput: one word per cycle; the byte register and the result register
// form a two-stage pipeline that advances whenever the result can move on.
// Reset: synchronous, active high; parsing restarts in the hunt for a start
// marker, counters and header fields clear, registers take default values.
module response_message_deframer_unit #(
  parameter int unsigned BUFFER_DEPTH = rmd_pkg::DefBufferDepth
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rmd_pkg::AddrWidth-1:0]   paddr,
  input  logic [rmd_pkg::DataWidth-1:0]   pwdata,
  output logic [rmd_pkg::DataWidth-1:0]   prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      event_res,
  output logic [7:0]                      payload_byte,
  output logic [15:0]                     payload_index,
  output logic                            in_buffer,
  output logic [15:0]                     message_id,
  output logic [15:0]                     payload_length
);
  import rmd_pkg::*;

  cfg_t cfg;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;
  logic       fire;

  phase_t      phase, phase_next;
  logic [15:0] byte_counter, byte_counter_next;
  logic [15:0] message_length, message_length_next;
  logic [15:0] message_ident, message_ident_next;

  event_t      ev;
  logic [7:0]  pbyte;
  logic [15:0] pidx;
  logic        inbuf;
  logic [15:0] plen;

  logic [15:0] cnt_inc;
  logic [15:0] len_full;
  logic [15:0] len_pay;
  logic        is_marker;

  rmd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign fire     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  assign cnt_inc   = byte_counter + 16'd1;
  assign len_full  = message_length;
  assign len_pay   = len_full - HdrBytes;
  assign is_marker = (s1_byte == cfg.start_marker);

  always_comb begin
    unique case (phase)
      PH_LEN_LO:  phase_next = PH_LEN_HI;
      PH_LEN_HI:  phase_next = PH_ID_LO;
      PH_ID_LO:   phase_next = PH_ID_HI;
      PH_ID_HI: begin
        if (len_full < HdrBytes || len_pay == 16'd0) begin
          phase_next = PH_HUNT;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: phase_next = (cnt_inc >= len_full) ? PH_HUNT : PH_PAYLOAD;
      default:    phase_next = is_marker ? PH_LEN_LO : PH_HUNT;
    endcase
  end

  always_comb begin
    ev                  = EV_HUNT;
    pbyte               = '0;
    pidx                = '0;
    inbuf               = 1'b0;
    plen                = '0;
    byte_counter_next   = byte_counter;
    message_length_next = message_length;
    message_ident_next  = message_ident;
    unique case (phase)
      PH_LEN_LO: begin
        ev                  = EV_HEADER;
        message_length_next = {8'd0, s1_byte};
      end
      PH_LEN_HI: begin
        ev                  = EV_HEADER;
        message_length_next = {s1_byte, message_length[7:0]};
      end
      PH_ID_LO: begin
        ev                 = EV_HEADER;
        message_ident_next = {8'd0, s1_byte};
      end
      PH_ID_HI: begin
        message_ident_next = {s1_byte, message_ident[7:0]};
        byte_counter_next  = '0;
        if (len_full < HdrBytes) begin
          ev = EV_LENERR;
        end else begin
          message_length_next = len_pay;
          if (len_pay == 16'd0) begin
            ev = EV_DONE;
          end else begin
            ev   = EV_HEADER;
            plen = len_pay;
          end
        end
      end
      PH_PAYLOAD: begin
        pbyte = s1_byte;
        pidx  = byte_counter;
        inbuf = (32'(byte_counter) < 32'(BUFFER_DEPTH));
        plen  = message_length;
        if (cnt_inc >= len_full) begin
          ev                = EV_DONE;
          byte_counter_next = '0;
        end else begin
          ev                = EV_PAYLOAD;
          byte_counter_next = cnt_inc;
        end
      end
      default: begin
        if (is_marker) begin
          ev                = EV_HEADER;
          byte_counter_next = '0;
        end else if (cnt_inc >= {8'd0, cfg.idle_limit}) begin
          ev                  = EV_TIMEOUT;
          message_length_next = '0;
          byte_counter_next   = '0;
        end else begin
          ev                = EV_HUNT;
          byte_counter_next = cnt_inc;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      byte_counter   <= '0;
      message_length <= '0;
      message_ident  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (fire) begin
        phase          <= phase_next;
        byte_counter   <= byte_counter_next;
        message_length <= message_length_next;
        message_ident  <= message_ident_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      event_res      <= ev;
      payload_byte   <= pbyte;
      payload_index  <= pidx;
      in_buffer      <= inbuf;
      message_id     <= message_ident_next;
      payload_length <= plen;
    end
  end

endmodule
